@@ rtl/wfs_pkg.sv @@
// Shared types, constants and helpers for the wall-follow steering step unit.
package wfs_pkg;

	localparam int unsigned RangeWidth    = 8;
	localparam int unsigned PowerWidth    = 7;
	localparam int unsigned GraceWidth    = 5;
	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned CfgDataWidth  = 8;

	typedef logic [RangeWidth-1:0]       range_t;
	typedef logic [PowerWidth-1:0]       power_t;
	typedef logic [GraceWidth-1:0]       grace_t;
	typedef logic [6:0]                  band_t;
	typedef logic [6:0]                  counts_t;
	typedef logic signed [7:0]           target_t;
	typedef logic [CfgDataWidth-1:0]     cfg_data_t;

	// Register indexes of the configuration port
	typedef enum logic [CfgIndexWidth-1:0] {
		REG_WALL_DISTANCE     = 3'd0,
		REG_ANGLE_BAND        = 3'd1,
		REG_SIDE_OPEN_LIMIT   = 3'd2,
		REG_FRONT_BLOCK_LIMIT = 3'd3,
		REG_GRACE_TICKS       = 3'd4,
		REG_CRUISE_POWER      = 3'd5,
		REG_TRIM_POWER        = 3'd6,
		REG_TURN_COUNTS       = 3'd7
	} cfg_index_t;

	typedef enum logic [2:0] {
		ANG_VERY_LOW  = 3'd0,
		ANG_LOW       = 3'd1,
		ANG_PARALLEL  = 3'd2,
		ANG_RAISED    = 3'd3,
		ANG_VERY_HIGH = 3'd4
	} angle_class_t;

	typedef enum logic [1:0] {
		DIST_ON_LINE = 2'd0,
		DIST_NEAR    = 2'd1,
		DIST_BEYOND  = 2'd2
	} dist_class_t;

	// Outer bound of the angle classes, as a signed wall difference
	localparam logic signed [8:0] VeryBound = 9'sd15;

	// Register reset values
	localparam range_t  WallDistanceReset    = 8'd55;
	localparam band_t   AngleBandReset       = 7'd5;
	localparam range_t  SideOpenLimitReset   = 8'd140;
	localparam range_t  FrontBlockLimitReset = 8'd80;
	localparam grace_t  GraceTicksReset      = 5'd20;
	localparam power_t  CruisePowerReset     = 7'd50;
	localparam power_t  TrimPowerReset       = 7'd8;
	localparam counts_t TurnCountsReset      = 7'd38;

	typedef struct packed {
		range_t  wall_distance;
		band_t   angle_band;
		range_t  side_open_limit;
		range_t  front_block_limit;
		grace_t  grace_ticks;
		power_t  cruise_power;
		power_t  trim_power;
		counts_t turn_counts;
	} cfg_t;

	typedef struct packed {
		range_t left_front;
		range_t left_back;
		range_t ahead;
		range_t right;
	} sample_t;

	// Smoothed ranges of the current request and its junction decision
	typedef struct packed {
		sample_t avg;
		logic    branch;
	} track_t;

	typedef struct packed {
		power_t       left_power;
		power_t       right_power;
		angle_class_t angle_class;
		dist_class_t  distance_class;
		logic         branch_taken;
		target_t      left_turn_target;
		target_t      right_turn_target;
	} result_t;

	// floor((old + raw) / 2) without losing the carry
	function automatic range_t smooth(range_t old, range_t raw);
		logic [RangeWidth:0] sum;
		sum = {1'b0, old} + {1'b0, raw};
		return sum[RangeWidth:1];
	endfunction

endpackage

@@ rtl/wfs_track.sv @@
// Running averages of the four ranges and the junction grace countdown.
module wfs_track (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  wfs_pkg::sample_t sample,
	input  wfs_pkg::cfg_t    cfg,
	output wfs_pkg::track_t  track
);
	import wfs_pkg::*;

	sample_t avg_q;
	grace_t  grace_q;
	grace_t  grace_dec;
	grace_t  grace_next;
	logic    open_seen;

	always_comb begin
		track.avg.left_front = smooth(avg_q.left_front, sample.left_front);
		track.avg.left_back  = smooth(avg_q.left_back, sample.left_back);
		track.avg.ahead      = smooth(avg_q.ahead, sample.ahead);
		track.avg.right      = smooth(avg_q.right, sample.right);
	end

	// Count down first, then test for a junction on the new averages
	always_comb begin
		grace_dec  = (grace_q != '0) ? grace_q - grace_t'(1) : '0;
		open_seen  = (track.avg.right > cfg.side_open_limit) ||
			(track.avg.left_front > cfg.side_open_limit) ||
			(track.avg.ahead < cfg.front_block_limit);
		track.branch = (grace_dec == '0) && open_seen;
		grace_next = track.branch ? cfg.grace_ticks : grace_dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= '0;
			grace_q <= GraceTicksReset;
		end else if (advance) begin
			avg_q   <= track.avg;
			grace_q <= grace_next;
		end
	end

`ifndef ASSERT_OFF
	a_reload_on_branch: assert property (@(posedge clk) disable iff (!arst_n)
		advance && track.branch |=> grace_q == $past(cfg.grace_ticks))
		else $error("grace count not reloaded after a junction");

	a_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (grace_q != '0) && !track.branch |=> grace_q == $past(grace_q) - grace_t'(1))
		else $error("grace count did not step down by one");
`endif

endmodule

@@ rtl/wfs_steer.sv @@
// Angle and distance classing, wheel powers and junction turn targets.
module wfs_steer (
	input  wfs_pkg::track_t  track,
	input  wfs_pkg::cfg_t    cfg,
	output wfs_pkg::result_t result
);
	import wfs_pkg::*;

	logic signed [8:0] diff;
	logic signed [8:0] band;
	power_t            trimmed;
	target_t           turn_pos;
	target_t           turn_neg;
	logic              below;
	logic              above;

	always_comb begin
		diff = $signed({1'b0, track.avg.left_front}) - $signed({1'b0, track.avg.left_back});
		band = $signed({2'b00, cfg.angle_band});

		// Tested in order, so a wide band can hide the low and high classes
		if (diff < -VeryBound) begin
			result.angle_class = ANG_VERY_LOW;
		end else if (diff < -band) begin
			result.angle_class = ANG_LOW;
		end else if (diff < band) begin
			result.angle_class = ANG_PARALLEL;
		end else if (diff < VeryBound) begin
			result.angle_class = ANG_RAISED;
		end else begin
			result.angle_class = ANG_VERY_HIGH;
		end

		if (track.avg.left_front < cfg.wall_distance) begin
			result.distance_class = DIST_NEAR;
		end else if (track.avg.left_front > cfg.wall_distance) begin
			result.distance_class = DIST_BEYOND;
		end else begin
			result.distance_class = DIST_ON_LINE;
		end
	end

	always_comb begin
		below   = (result.angle_class == ANG_VERY_LOW) || (result.angle_class == ANG_LOW);
		above   = (result.angle_class == ANG_RAISED) || (result.angle_class == ANG_VERY_HIGH);
		trimmed = (cfg.cruise_power > cfg.trim_power) ? cfg.cruise_power - cfg.trim_power : '0;

		result.left_power  = cfg.cruise_power;
		result.right_power = cfg.cruise_power;
		case (result.distance_class)
			DIST_NEAR: begin
				if (!above) result.right_power = trimmed;
			end
			DIST_BEYOND: begin
				if (!below) result.left_power = trimmed;
			end
			default: begin
				if (below) result.right_power = trimmed;
				else if (above) result.left_power = trimmed;
			end
		endcase
	end

	always_comb begin
		turn_pos = $signed({1'b0, cfg.turn_counts});
		turn_neg = -turn_pos;
		result.branch_taken = track.branch;
		if (!track.branch) begin
			result.left_turn_target  = '0;
			result.right_turn_target = '0;
		end else if (track.avg.left_front > track.avg.right) begin
			result.left_turn_target  = turn_pos;
			result.right_turn_target = turn_neg;
		end else begin
			result.left_turn_target  = turn_neg;
			result.right_turn_target = turn_pos;
		end
	end

endmodule

@@ rtl/wall_follow_steering_step_unit.sv @@
// Top level of the wall-follow steering step unit.
//
// One request is one sensor tick: four raw ranges go in, one steering result
// comes out. The unit takes a new request in every cycle and gives one result
// per cycle while the output is not stalled; a request passes through the
// input register and then the result register. The running averages and the
// grace countdown are updated as a request moves from the input register into
// the result register, so the next request always sees the state this one
// leaves. The result register parts the two sides: a new request is taken
// into an empty input register while a finished result still waits.
// Configuration writes are taken at once (cfg_ready is always high) and must
// only be made while no request is in flight.
module wall_follow_steering_step_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  wfs_pkg::range_t        left_front_range,
	input  wfs_pkg::range_t        left_back_range,
	input  wfs_pkg::range_t        ahead_range,
	input  wfs_pkg::range_t        right_range,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output wfs_pkg::power_t        left_power,
	output wfs_pkg::power_t        right_power,
	output logic [2:0]             angle_class,
	output logic [1:0]             distance_class,
	output logic                   branch_taken,
	output wfs_pkg::target_t       left_turn_target,
	output wfs_pkg::target_t       right_turn_target,
	// configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [wfs_pkg::CfgIndexWidth-1:0] cfg_index,
	input  wfs_pkg::cfg_data_t     cfg_data
);
	import wfs_pkg::*;

	cfg_t    cfg_q;
	sample_t sample_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	track_t  track;
	result_t result;

	// Move the held request on when the result register is free or draining
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers; every index names a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wall_distance     <= WallDistanceReset;
			cfg_q.angle_band        <= AngleBandReset;
			cfg_q.side_open_limit   <= SideOpenLimitReset;
			cfg_q.front_block_limit <= FrontBlockLimitReset;
			cfg_q.grace_ticks       <= GraceTicksReset;
			cfg_q.cruise_power      <= CruisePowerReset;
			cfg_q.trim_power        <= TrimPowerReset;
			cfg_q.turn_counts       <= TurnCountsReset;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				REG_WALL_DISTANCE:     cfg_q.wall_distance     <= cfg_data;
				REG_ANGLE_BAND:        cfg_q.angle_band        <= cfg_data[6:0];
				REG_SIDE_OPEN_LIMIT:   cfg_q.side_open_limit   <= cfg_data;
				REG_FRONT_BLOCK_LIMIT: cfg_q.front_block_limit <= cfg_data;
				REG_GRACE_TICKS:       cfg_q.grace_ticks       <= cfg_data[4:0];
				REG_CRUISE_POWER:      cfg_q.cruise_power      <= cfg_data[6:0];
				REG_TRIM_POWER:        cfg_q.trim_power        <= cfg_data[6:0];
				REG_TURN_COUNTS:       cfg_q.turn_counts       <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Input register: hold the raw ranges until the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1.left_front <= left_front_range;
			sample_s1.left_back  <= left_back_range;
			sample_s1.ahead      <= ahead_range;
			sample_s1.right      <= right_range;
		end
	end

	wfs_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.sample  (sample_s1),
		.cfg     (cfg_q),
		.track   (track)
	);

	wfs_steer u_steer (
		.track  (track),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register: drop the result once taken, load the next on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid         = valid_s2;
	assign left_power        = result_s2.left_power;
	assign right_power       = result_s2.right_power;
	assign angle_class       = result_s2.angle_class;
	assign distance_class    = result_s2.distance_class;
	assign branch_taken      = result_s2.branch_taken;
	assign left_turn_target  = result_s2.left_turn_target;
	assign right_turn_target = result_s2.right_turn_target;

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the result register is empty");

	a_no_branch_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !branch_taken |-> (left_turn_target == '0) && (right_turn_target == '0))
		else $error("turn target given without a junction");

	a_targets_opposed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken |-> left_turn_target == -right_turn_target)
		else $error("junction turn targets are not opposed");
`endif

endmodule
